// ===== hw/rtl/sha_pkg.sv =====
// SHA-256 stream hasher: shared package.
// Holds the round constants, the initial hash, the controller state type, the
// controller-to-datapath command and status structs, and the sigma functions.
`timescale 1ns / 1ps

package sha_pkg;

   localparam int WORD_W = 32;
   localparam int NUM_WORDS = 8;
   localparam int NUM_ROUNDS = 64;
   localparam int TOTAL_W = 61;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] FILL_BEFORE_LEN = 6'd55;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST_IDX = 3'd7;

   localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [NUM_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MARK  = 7'b0000010,
      ST_ZERO  = 7'b0000100,
      ST_LEN   = 7'b0001000,
      ST_ROUND = 7'b0010000,
      ST_FOLD  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      SRC_DATA = 2'd0,
      SRC_MARK = 2'd1,
      SRC_ZERO = 2'd2,
      SRC_LEN  = 2'd3
   } byte_src_type;

   typedef struct packed {
      logic         push;
      byte_src_type byte_src;
      logic         count_byte;
      logic         init_work;
      logic         round_en;
      logic [5:0]   round_idx;
      logic         fold;
      logic         out_shift;
      logic         restart;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } status_type;

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

// ===== hw/rtl/sha_req_if.sv =====
// SHA-256 stream hasher: input channel interface.
// Carries valid, ready and one message word (mode and data byte); no dependencies.
`timescale 1ns / 1ps

interface sha_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

// ===== hw/rtl/sha_rsp_if.sv =====
// SHA-256 stream hasher: result channel interface.
// Carries valid, ready and one digest word with its last marker; no dependencies.
`timescale 1ns / 1ps

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        word_last;

   modport source (output valid, output digest_word, output word_last, input ready);
   modport sink (input valid, input digest_word, input word_last, output ready);
endinterface

// ===== hw/rtl/sha_ctrl.sv =====
// SHA-256 stream hasher: controller state machine.
// Sequences byte intake, padding, rounds and digest output; uses sha_pkg.
`timescale 1ns / 1ps

module sha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_last,
   input  sha_pkg::status_type status,
   output sha_pkg::cmd_type    cmd
);

   sha_pkg::state_type state_ff, state_in;
   sha_pkg::state_type ret_ff, ret_in;
   logic [5:0]         rnd_ff, rnd_in;
   logic [2:0]         outc_ff, outc_in;
   logic               block_full;

   assign block_full = (status.fill == sha_pkg::FILL_LAST);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      rnd_in        = rnd_ff;
      outc_in       = outc_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      rsp_last      = 1'b0;
      cmd           = '0;
      cmd.byte_src  = sha_pkg::SRC_DATA;
      cmd.round_idx = rnd_ff;

      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_mode) begin
                  cmd.push       = 1'b1;
                  cmd.count_byte = 1'b1;
                  if (block_full) begin
                     cmd.init_work = 1'b1;
                     ret_in        = sha_pkg::ST_IDLE;
                     state_in      = sha_pkg::ST_ROUND;
                  end
               end else begin
                  state_in = sha_pkg::ST_MARK;
               end
            end
         end
         sha_pkg::ST_MARK: begin
            cmd.push     = 1'b1;
            cmd.byte_src = sha_pkg::SRC_MARK;
            if (block_full) begin
               cmd.init_work = 1'b1;
               ret_in        = sha_pkg::ST_ZERO;
               state_in      = sha_pkg::ST_ROUND;
            end else if (status.fill == sha_pkg::FILL_BEFORE_LEN) begin
               state_in = sha_pkg::ST_LEN;
            end else begin
               state_in = sha_pkg::ST_ZERO;
            end
         end
         sha_pkg::ST_ZERO: begin
            cmd.push     = 1'b1;
            cmd.byte_src = sha_pkg::SRC_ZERO;
            if (block_full) begin
               cmd.init_work = 1'b1;
               ret_in        = sha_pkg::ST_ZERO;
               state_in      = sha_pkg::ST_ROUND;
            end else if (status.fill == sha_pkg::FILL_BEFORE_LEN) begin
               state_in = sha_pkg::ST_LEN;
            end
         end
         sha_pkg::ST_LEN: begin
            cmd.push     = 1'b1;
            cmd.byte_src = sha_pkg::SRC_LEN;
            if (block_full) begin
               cmd.init_work = 1'b1;
               ret_in        = sha_pkg::ST_OUT;
               state_in      = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 6'd1;
            if (rnd_ff == sha_pkg::ROUND_LAST) begin
               state_in = sha_pkg::ST_FOLD;
            end
         end
         sha_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         sha_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            rsp_last  = (outc_ff == sha_pkg::WORD_LAST_IDX);
            if (rsp_ready) begin
               cmd.out_shift = 1'b1;
               outc_in       = outc_ff + 3'd1;
               if (outc_ff == sha_pkg::WORD_LAST_IDX) begin
                  cmd.restart = 1'b1;
                  state_in    = sha_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         ret_ff   <= sha_pkg::ST_IDLE;
         rnd_ff   <= '0;
         outc_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         rnd_ff   <= rnd_in;
         outc_ff  <= outc_in;
      end
   end

endmodule

// ===== hw/rtl/sha_dpath.sv =====
// SHA-256 stream hasher: datapath.
// Block shift line doubling as schedule window, round logic, hash and length
// registers; driven by sha_ctrl commands, uses sha_pkg.
`timescale 1ns / 1ps

module sha_dpath (
   input  logic                clock,
   input  logic                reset,
   input  sha_pkg::cmd_type    cmd,
   input  logic [7:0]          data_byte,
   output sha_pkg::status_type status,
   output logic [31:0]         digest_word
);

   // Word j of the window sits at [511-32j -: 32]; word 0 is the oldest.
   logic [511:0]               win_ff, win_in;
   logic [31:0]                wv_ff   [sha_pkg::NUM_WORDS];
   logic [31:0]                wv_in   [sha_pkg::NUM_WORDS];
   logic [31:0]                hash_ff [sha_pkg::NUM_WORDS];
   logic [31:0]                hash_in [sha_pkg::NUM_WORDS];
   logic [5:0]                 fill_ff, fill_in;
   logic [sha_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic [63:0] bit_len;
   logic [5:0]  len_shift;
   logic [7:0]  push_byte;
   logic [31:0] w_sched, w_cur, t1, t2;

   assign bit_len   = {total_ff, 3'b000};
   assign len_shift = {3'(3'd7 - fill_ff[2:0]), 3'b000};

   always_comb begin
      case (cmd.byte_src)
         sha_pkg::SRC_DATA: push_byte = data_byte;
         sha_pkg::SRC_MARK: push_byte = sha_pkg::PAD_MARK;
         sha_pkg::SRC_ZERO: push_byte = 8'h00;
         sha_pkg::SRC_LEN:  push_byte = 8'(bit_len >> len_shift);
         default:           push_byte = 8'h00;
      endcase
   end

   // Taps: W[t-16] word 0, W[t-15] word 1, W[t-7] word 9, W[t-2] word 14.
   assign w_sched = win_ff[511:480] + sha_pkg::small_s0(win_ff[479:448])
                  + win_ff[223:192] + sha_pkg::small_s1(win_ff[63:32]);
   assign w_cur   = cmd.round_idx[5:4] == 2'b00 ? win_ff[511:480] : w_sched;

   assign t1 = wv_ff[7] + sha_pkg::big_s1(wv_ff[4])
             + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
             + sha_pkg::ROUND_K[cmd.round_idx] + w_cur;
   assign t2 = sha_pkg::big_s0(wv_ff[0])
             + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));

   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      wv_in    = wv_ff;
      hash_in  = hash_ff;

      if (cmd.push) begin
         win_in  = {win_ff[503:0], push_byte};
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.count_byte) begin
         total_in = total_ff + sha_pkg::TOTAL_W'(1);
      end

      if (cmd.init_work) begin
         wv_in = hash_ff;
      end else if (cmd.round_en) begin
         win_in   = {win_ff[479:0], w_cur};
         wv_in[7] = wv_ff[6];
         wv_in[6] = wv_ff[5];
         wv_in[5] = wv_ff[4];
         wv_in[4] = wv_ff[3] + t1;
         wv_in[3] = wv_ff[2];
         wv_in[2] = wv_ff[1];
         wv_in[1] = wv_ff[0];
         wv_in[0] = t1 + t2;
      end

      if (cmd.fold) begin
         for (int i = 0; i < sha_pkg::NUM_WORDS; i++) begin
            hash_in[i] = hash_ff[i] + wv_ff[i];
         end
      end else if (cmd.out_shift) begin
         for (int i = 0; i < sha_pkg::NUM_WORDS - 1; i++) begin
            hash_in[i] = hash_ff[i + 1];
         end
         hash_in[sha_pkg::NUM_WORDS - 1] = hash_ff[0];
      end

      if (cmd.restart) begin
         hash_in  = sha_pkg::INIT_HASH;
         total_in = '0;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= sha_pkg::INIT_HASH;
         fill_ff  <= '0;
         total_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      wv_ff  <= wv_in;
   end

   assign status.fill = fill_ff;
   assign digest_word = hash_ff[0];

endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Operation: a data word is taken while idle; a word that completes a 64-byte block
// starts 64 rounds and one hash fold, and no words are taken meanwhile. A finish word
// starts padding: one padding byte per cycle up to the block end, pausing while each
// padded block (one or two) is hashed, then eight digest words at one per cycle while rsp ready.
// Message byte throughput is set by the single round unit.
// Reset (synchronous, active high): initial hash loaded, counts cleared, idle.
`timescale 1ns / 1ps

module sha256_stream_hasher (
   input  logic    clock,
   input  logic    reset,
   sha_req_if.sink   req_ch,
   sha_rsp_if.source rsp_ch
);

   // Command and status bundles between the sequencer and the datapath.
   sha_pkg::cmd_type    cmd;
   sha_pkg::status_type status;

   // Controller: owns the handshake, the padding phases, the round counter
   // and the digest word counter. Take words only in its idle state; hold
   // the request side off through padding, rounds and output.
   sha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_last  (rsp_ch.word_last),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: the 512-bit shift line packs bytes big-endian and then serves
   // as the rolling schedule window; the hash registers rotate during output
   // so the current digest word always sits in the first one.
   sha_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_ch.data_byte),
      .status      (status),
      .digest_word (rsp_ch.digest_word)
   );

endmodule
